/* src/gdu_pkg.sv */
// ----------------------------------------------------------------------------
// gdu_pkg
// Shared types, widths, codes and calendar tables for the Gregorian date unit.
// ----------------------------------------------------------------------------
package gdu_pkg;

  // Field widths
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned WYEAR_W  = 15;   // working year, holds MAX_YEAR + 1
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned NDAYS_W  = 16;
  localparam int unsigned DIFF_W   = 22;
  localparam int unsigned SERIAL_W = 24;
  localparam int unsigned QUOT_W   = 8;    // year / 100
  localparam int unsigned LDAYS_W  = 12;   // leap days before a year
  localparam int unsigned Y365_W   = 23;

  // Last year the unit accepts
  localparam int unsigned MAX_YEAR = 9999;

  // Divide by 100 as multiply by reciprocal, exact for values below 43690
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned DIV100_PW    = YEAR_W + 13;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ADD  = 2'd1,
    OP_DIFF = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_MONTH = 2'd1,
    ST_BAD_DAY   = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // Controller to datapath commands, at most one high per cycle
  typedef struct packed {
    logic latch;
    logic sel_cur;
    logic div;
    logic modc;
    logic check;
    logic serial;
    logic step;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    opcode_t op;
    logic    date_ok;
    logic    add_done;
  } dp_stat_t;

  // Days in month; zero for codes that are not a month
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1:    r = 5'd31;
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd3:    r = 5'd31;
      4'd4:    r = 5'd30;
      4'd5:    r = 5'd31;
      4'd6:    r = 5'd30;
      4'd7:    r = 5'd31;
      4'd8:    r = 5'd31;
      4'd9:    r = 5'd30;
      4'd10:   r = 5'd31;
      4'd11:   r = 5'd30;
      4'd12:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Days in the months before m, common year
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* src/gdu_if.sv */
// ----------------------------------------------------------------------------
// gdu_if
// Valid/ready channels of the Gregorian date unit: request and result.
// ----------------------------------------------------------------------------
interface gdu_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          opcode;
  logic [gdu_pkg::YEAR_W-1:0]          in_year;
  logic [gdu_pkg::MONTH_W-1:0]         in_month;
  logic [gdu_pkg::DAY_W-1:0]           in_day;
  logic [gdu_pkg::NDAYS_W-1:0]         num_days;

  modport source (output valid, opcode, in_year, in_month, in_day, num_days,
                  input ready);
  modport sink   (input valid, opcode, in_year, in_month, in_day, num_days,
                  output ready);
endinterface

interface gdu_out_if;
  logic                                valid;
  logic                                ready;
  logic [gdu_pkg::YEAR_W-1:0]          out_year;
  logic [gdu_pkg::MONTH_W-1:0]         out_month;
  logic [gdu_pkg::DAY_W-1:0]           out_day;
  logic [gdu_pkg::DIFF_W-1:0]          day_difference;
  logic [1:0]                          status;

  modport source (output valid, out_year, out_month, out_day, day_difference, status,
                  input ready);
  modport sink   (input valid, out_year, out_month, out_day, day_difference, status,
                  output ready);
endinterface

/* src/gdu_dp.sv */
// ----------------------------------------------------------------------------
// gdu_dp
// Datapath: stored date, working date, divide-by-100 unit, serial day number,
// day-walk step and the result register.
// ----------------------------------------------------------------------------
module gdu_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gdu_pkg::dp_cmd_t              cmd,
  output gdu_pkg::dp_stat_t             stat,
  input  logic [1:0]                    in_opcode,
  input  logic [gdu_pkg::YEAR_W-1:0]    in_year,
  input  logic [gdu_pkg::MONTH_W-1:0]   in_month,
  input  logic [gdu_pkg::DAY_W-1:0]     in_day,
  input  logic [gdu_pkg::NDAYS_W-1:0]   in_num_days,
  output logic [gdu_pkg::YEAR_W-1:0]    out_year,
  output logic [gdu_pkg::MONTH_W-1:0]   out_month,
  output logic [gdu_pkg::DAY_W-1:0]     out_day,
  output logic [gdu_pkg::DIFF_W-1:0]    out_diff,
  output logic [1:0]                    out_status
);

  localparam logic [gdu_pkg::WYEAR_W-1:0] MAX_Y = gdu_pkg::WYEAR_W'(gdu_pkg::MAX_YEAR);

  // Stored date
  logic [gdu_pkg::YEAR_W-1:0]   cur_year_r;
  logic [gdu_pkg::MONTH_W-1:0]  cur_month_r;
  logic [gdu_pkg::DAY_W-1:0]    cur_day_r;

  // Working item
  gdu_pkg::opcode_t             op_r;
  gdu_pkg::status_t             stat_r;
  logic [gdu_pkg::NDAYS_W-1:0]  n_r;
  logic [gdu_pkg::WYEAR_W-1:0]  wy_r;
  logic [gdu_pkg::MONTH_W-1:0]  wm_r;
  logic [gdu_pkg::DAY_W-1:0]    wd_r;

  // Year decomposition
  logic [gdu_pkg::QUOT_W-1:0]   qy_r;      // y / 100
  logic [gdu_pkg::QUOT_W-1:0]   qp_r;      // (y - 1) / 100
  logic [1:0]                   mod4_r;
  logic [6:0]                   mod100_r;
  logic [1:0]                   cmod4_r;   // (y / 100) mod 4
  logic [gdu_pkg::Y365_W-1:0]   y365_r;
  logic [gdu_pkg::LDAYS_W-1:0]  ld_r;

  // Serial day numbers of the two dates
  logic [gdu_pkg::SERIAL_W-1:0] s_r;
  logic [gdu_pkg::SERIAL_W-1:0] b_r;

  // Result register
  logic [gdu_pkg::YEAR_W-1:0]   out_year_r;
  logic [gdu_pkg::MONTH_W-1:0]  out_month_r;
  logic [gdu_pkg::DAY_W-1:0]    out_day_r;
  logic [gdu_pkg::DIFF_W-1:0]   out_diff_r;
  gdu_pkg::status_t             out_status_r;

  // Combinational terms
  logic [gdu_pkg::YEAR_W-1:0]      py;
  logic [gdu_pkg::DIV100_PW-1:0]   prod_y;
  logic [gdu_pkg::DIV100_PW-1:0]   prod_p;
  logic [gdu_pkg::YEAR_W-1:0]      hundred_q;
  logic [gdu_pkg::Y365_W-1:0]      wy_ext;
  logic [gdu_pkg::Y365_W-1:0]      y365;
  logic [gdu_pkg::LDAYS_W-1:0]     ld;
  logic                            leap;
  logic [gdu_pkg::DAY_W-1:0]       mdays;
  logic [8:0]                      ylen;
  logic [5:0]                      rem;
  logic [gdu_pkg::WYEAR_W-1:0]     y_inc;
  logic                            y_over;
  logic [gdu_pkg::SERIAL_W-1:0]    serial;
  logic [gdu_pkg::SERIAL_W-1:0]    sdiff;
  logic                            commit;
  gdu_pkg::status_t                chk;

  // Divide by 100 through reciprocal multiply
  assign py     = wy_r[gdu_pkg::YEAR_W-1:0] - gdu_pkg::YEAR_W'(1);
  assign prod_y = gdu_pkg::DIV100_PW'(wy_r[gdu_pkg::YEAR_W-1:0])
                * gdu_pkg::DIV100_PW'(gdu_pkg::DIV100_MUL);
  assign prod_p = gdu_pkg::DIV100_PW'(py) * gdu_pkg::DIV100_PW'(gdu_pkg::DIV100_MUL);

  // 100 * q and 365 * y by shift-add
  assign hundred_q = (gdu_pkg::YEAR_W'(qy_r) << 6) + (gdu_pkg::YEAR_W'(qy_r) << 5)
                   + (gdu_pkg::YEAR_W'(qy_r) << 2);
  assign wy_ext    = gdu_pkg::Y365_W'(wy_r[gdu_pkg::YEAR_W-1:0]);
  assign y365      = (wy_ext << 8) + (wy_ext << 6) + (wy_ext << 5)
                   + (wy_ext << 3) + (wy_ext << 2) + wy_ext;

  // Leap days in the years before y: p/4 - p/100 + p/400
  assign ld = gdu_pkg::LDAYS_W'(py >> 2) - gdu_pkg::LDAYS_W'(qp_r)
            + gdu_pkg::LDAYS_W'(qp_r >> 2);

  // Calendar of the working year
  assign leap  = (mod4_r == 2'd0) && ((mod100_r != 7'd0) || (cmod4_r == 2'd0));
  assign mdays = gdu_pkg::month_days(wm_r, leap);
  assign ylen  = 9'd365 + 9'(leap);
  assign rem   = 6'(mdays) - 6'(wd_r) + 6'd1;
  assign y_inc = wy_r + gdu_pkg::WYEAR_W'(1);
  assign y_over = (y_inc > MAX_Y);

  // Date validation of the working date
  always_comb begin
    if ((wy_r == '0) || (wy_r > MAX_Y)) begin
      chk = gdu_pkg::ST_OVERFLOW;
    end else if ((wm_r < gdu_pkg::MONTH_JAN) || (wm_r > gdu_pkg::MONTH_DEC)) begin
      chk = gdu_pkg::ST_BAD_MONTH;
    end else if ((wd_r == '0) || (wd_r > mdays)) begin
      chk = gdu_pkg::ST_BAD_DAY;
    end else begin
      chk = gdu_pkg::ST_OK;
    end
  end

  // Serial day number of the working date
  assign serial = gdu_pkg::SERIAL_W'(y365_r) + gdu_pkg::SERIAL_W'(ld_r)
                + gdu_pkg::SERIAL_W'(wd_r) + gdu_pkg::SERIAL_W'(gdu_pkg::days_before(wm_r))
                + gdu_pkg::SERIAL_W'(leap && (wm_r > gdu_pkg::MONTH_FEB));

  assign sdiff  = (s_r >= b_r) ? (s_r - b_r) : (b_r - s_r);
  assign commit = ((op_r == gdu_pkg::OP_LOAD) || (op_r == gdu_pkg::OP_ADD))
                && (stat_r == gdu_pkg::ST_OK);

  // Stored date
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_year_r  <= gdu_pkg::YEAR_W'(1);
      cur_month_r <= gdu_pkg::MONTH_JAN;
      cur_day_r   <= gdu_pkg::DAY_W'(1);
    end else if (cmd.finish && commit) begin
      cur_year_r  <= wy_r[gdu_pkg::YEAR_W-1:0];
      cur_month_r <= wm_r;
      cur_day_r   <= wd_r;
    end
  end

  // Working date, walk and decomposition
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= gdu_pkg::opcode_t'(in_opcode);
      stat_r <= gdu_pkg::ST_OK;
      n_r    <= in_num_days;
      if (gdu_pkg::opcode_t'(in_opcode) == gdu_pkg::OP_ADD) begin
        wy_r <= gdu_pkg::WYEAR_W'(cur_year_r);
        wm_r <= cur_month_r;
        wd_r <= cur_day_r;
      end else begin
        wy_r <= gdu_pkg::WYEAR_W'(in_year);
        wm_r <= in_month;
        wd_r <= in_day;
      end
    end else if (cmd.sel_cur) begin
      wy_r <= gdu_pkg::WYEAR_W'(cur_year_r);
      wm_r <= cur_month_r;
      wd_r <= cur_day_r;
    end else if (cmd.div) begin
      qy_r <= prod_y[gdu_pkg::DIV100_SHIFT +: gdu_pkg::QUOT_W];
      qp_r <= prod_p[gdu_pkg::DIV100_SHIFT +: gdu_pkg::QUOT_W];
    end else if (cmd.modc) begin
      mod4_r   <= wy_r[1:0];
      mod100_r <= 7'(wy_r[gdu_pkg::YEAR_W-1:0] - hundred_q);
      cmod4_r  <= qy_r[1:0];
      y365_r   <= y365;
      ld_r     <= ld;
    end else if (cmd.check) begin
      stat_r <= chk;
    end else if (cmd.serial) begin
      s_r <= serial;
      b_r <= s_r;
    end else if (cmd.step) begin
      if ((wm_r == gdu_pkg::MONTH_JAN) && (wd_r == gdu_pkg::DAY_W'(1))
          && (n_r >= gdu_pkg::NDAYS_W'(ylen))) begin
        // Whole year from Jan 1
        n_r <= n_r - gdu_pkg::NDAYS_W'(ylen);
        if (y_over) begin
          stat_r <= gdu_pkg::ST_OVERFLOW;
        end else begin
          wy_r     <= y_inc;
          mod4_r   <= mod4_r + 2'd1;
          mod100_r <= (mod100_r == 7'd99) ? 7'd0 : mod100_r + 7'd1;
          if (mod100_r == 7'd99) begin
            cmod4_r <= cmod4_r + 2'd1;
          end
        end
      end else if (n_r >= gdu_pkg::NDAYS_W'(rem)) begin
        // Rest of the month, to the 1st of the next
        n_r  <= n_r - gdu_pkg::NDAYS_W'(rem);
        wd_r <= gdu_pkg::DAY_W'(1);
        if (wm_r == gdu_pkg::MONTH_DEC) begin
          if (y_over) begin
            stat_r <= gdu_pkg::ST_OVERFLOW;
          end else begin
            wm_r     <= gdu_pkg::MONTH_JAN;
            wy_r     <= y_inc;
            mod4_r   <= mod4_r + 2'd1;
            mod100_r <= (mod100_r == 7'd99) ? 7'd0 : mod100_r + 7'd1;
            if (mod100_r == 7'd99) begin
              cmod4_r <= cmod4_r + 2'd1;
            end
          end
        end else begin
          wm_r <= wm_r + gdu_pkg::MONTH_W'(1);
        end
      end else begin
        // Lands inside the month
        wd_r <= wd_r + gdu_pkg::DAY_W'(n_r);
        n_r  <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_year_r   <= commit ? wy_r[gdu_pkg::YEAR_W-1:0] : cur_year_r;
      out_month_r  <= commit ? wm_r : cur_month_r;
      out_day_r    <= commit ? wd_r : cur_day_r;
      out_diff_r   <= ((op_r == gdu_pkg::OP_DIFF) && (stat_r == gdu_pkg::ST_OK))
                    ? sdiff[gdu_pkg::DIFF_W-1:0] : '0;
      out_status_r <= stat_r;
    end
  end

  assign stat.op       = op_r;
  assign stat.date_ok  = (stat_r == gdu_pkg::ST_OK);
  assign stat.add_done = (n_r == '0) || (stat_r != gdu_pkg::ST_OK);

  assign out_year   = out_year_r;
  assign out_month  = out_month_r;
  assign out_day    = out_day_r;
  assign out_diff   = out_diff_r;
  assign out_status = out_status_r;

endmodule

/* src/gdu_ctrl.sv */
// ----------------------------------------------------------------------------
// gdu_ctrl
// Controller: sequences decomposition, check, serial numbers and the day walk,
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
module gdu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output gdu_pkg::dp_cmd_t   cmd,
  input  gdu_pkg::dp_stat_t  stat
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV    = 8'b0000_0010,
    S_MOD    = 8'b0000_0100,
    S_CHECK  = 8'b0000_1000,
    S_SERIAL = 8'b0001_0000,
    S_SELCUR = 8'b0010_0000,
    S_STEP   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   pass2_r, pass2_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    pass2_nxt = pass2_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          pass2_nxt = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.modc = 1'b1;
        if (stat.op == gdu_pkg::OP_ADD) begin
          state_nxt = S_STEP;
        end else if (stat.op == gdu_pkg::OP_NOP) begin
          state_nxt = S_FINISH;
        end else if (pass2_r) begin
          state_nxt = S_SERIAL;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = (stat.op == gdu_pkg::OP_DIFF) ? S_SERIAL : S_FINISH;
      end
      S_SERIAL: begin
        if (!stat.date_ok || pass2_r) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SELCUR;
        end
        cmd.serial = stat.date_ok;
      end
      S_SELCUR: begin
        cmd.sel_cur = 1'b1;
        pass2_nxt   = 1'b1;
        state_nxt   = S_DIV;
      end
      S_STEP: begin
        if (stat.add_done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result beat held until taken
  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass2_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass2_r     <= pass2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* src/gregorian_date_unit.sv */
// Operation: a load decodes and checks the given date; a difference also
//   numbers it and then the stored date; an add walks by month or whole year.
// Throughput: one request at a time; the next request is taken once the
//   controller is back in idle, while the previous result may still wait.
// Reset (rst_n low, synchronous): stored date returns to year 1, January 1.
// ----------------------------------------------------------------------------
// gregorian_date_unit
// Holds one Gregorian date; loads a checked date, adds a day count, gives
// the day distance to another date, or reports the stored date unchanged.
// ----------------------------------------------------------------------------
module gregorian_date_unit (
  input  logic       clk,
  input  logic       rst_n,
  gdu_in_if.sink     in_bus,
  gdu_out_if.source  out_bus
);

  gdu_pkg::dp_cmd_t  cmd;
  gdu_pkg::dp_stat_t stat;

  // Sequencer
  gdu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Date arithmetic
  gdu_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_opcode   (in_bus.opcode),
    .in_year     (in_bus.in_year),
    .in_month    (in_bus.in_month),
    .in_day      (in_bus.in_day),
    .in_num_days (in_bus.num_days),
    .out_year    (out_bus.out_year),
    .out_month   (out_bus.out_month),
    .out_day     (out_bus.out_day),
    .out_diff    (out_bus.day_difference),
    .out_status  (out_bus.status)
  );

`ifndef NO_ASSERTIONS
  // Busy after a request beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> !in_bus.ready)
    else $error("input taken again right after a request beat");

  // Reported date is always a stored, valid date
  a_result_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (out_bus.out_month >= gdu_pkg::MONTH_JAN)
                   && (out_bus.out_month <= gdu_pkg::MONTH_DEC)
                   && (out_bus.out_day != '0)
                   && (out_bus.out_year != '0))
    else $error("result beat carries an invalid stored date");

  // Failed operation reports no distance
  a_error_no_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && (out_bus.status != gdu_pkg::ST_OK))
      |-> (out_bus.day_difference == '0))
    else $error("error result with nonzero day difference");

  // Only one datapath command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("several datapath commands in one cycle");
`endif

endmodule
